FILE: hdl/peak_hold_bar_meter_top_defines.svh
// Assertion macros for the checker file of the bar meter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PEAK_HOLD_BAR_METER_TOP_DEFINES_SVH
`define PEAK_HOLD_BAR_METER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PHBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/phbm_pkg.sv
`default_nettype none

package phbm_pkg;

    // Size of the bar bank.
    localparam int MAX_BARS = 256;
    localparam int BAR_AW   = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

    localparam int LEVEL_W  = 19;
    localparam int FALL_W   = 20;
    localparam int HOLD_W   = 3;
    localparam int GAIN_W   = 16;
    localparam int ENERGY_W = 17;
    localparam int ROWS_W   = 8;
    localparam int STEP_W   = 8;
    localparam int CELL_W   = 8;
    localparam int PROD_W   = LEVEL_W + GAIN_W;
    localparam int TPROD_W  = ENERGY_W + ROWS_W;

    localparam logic [ENERGY_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = '1;
    localparam logic [FALL_W-1:0]   FALL_MAX   = '1;
    localparam logic [GAIN_W-1:0]   IDLE_GAIN  = 16'd55706;
    localparam logic [LEVEL_W-1:0]  SNAP_LIMIT = 19'd128;

    localparam logic [ROWS_W-1:0]   ROW_COUNT_RESET    = 8'd24;
    localparam logic [ENERGY_W-1:0] ENERGY_FLOOR_RESET = 17'd2621;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    typedef enum logic {
        REG_ROW_COUNT    = 1'b0,
        REG_ENERGY_FLOOR = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]          bar_index;
        logic [ENERGY_W-1:0] energy;
        logic                active;
        logic [GAIN_W-1:0]   attack_gain;
        logic [GAIN_W-1:0]   decay_gain;
        logic [HOLD_W-1:0]   hold_reload;
        logic [STEP_W-1:0]   fall_step;
    } item_t;

    typedef struct packed {
        logic [7:0]        bar_out;
        logic [CELL_W-1:0] bar_cells;
        logic [2:0]        eighths;
        logic [CELL_W-1:0] peak_row;
        logic              peak_visible;
    } result_t;

    typedef struct packed {
        logic [ROWS_W-1:0]   row_count;
        logic [ENERGY_W-1:0] energy_floor;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] bar_level;
        logic [LEVEL_W-1:0] peak_level;
        logic [HOLD_W-1:0]  hold_count;
        logic [FALL_W-1:0]  fall_speed;
    } bar_state_t;

    typedef struct packed {
        logic              en;
        logic [BAR_AW-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic              en;
        logic [BAR_AW-1:0] addr;
        bar_state_t        data;
    } ram_wr_t;

endpackage

`default_nettype wire

FILE: hdl/phbm_cfg_regs.sv
`default_nettype none

module phbm_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [phbm_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [phbm_pkg::CFG_DW-1:0]  pwdata,
    output logic      [phbm_pkg::CFG_DW-1:0]  prdata,
    output logic                              pready,
    output phbm_pkg::cfg_t                    cfg
);

    logic [phbm_pkg::ROWS_W-1:0]   row_count_reg;
    logic [phbm_pkg::ENERGY_W-1:0] energy_floor_reg;
    phbm_pkg::cfg_reg_t            reg_sel;
    logic                          wr_en;

    // Registers sit on a four-byte stride, so the low address bits only pick a byte.
    assign reg_sel = phbm_pkg::cfg_reg_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= phbm_pkg::ROW_COUNT_RESET;
            energy_floor_reg <= phbm_pkg::ENERGY_FLOOR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                phbm_pkg::REG_ROW_COUNT:    row_count_reg    <= pwdata[phbm_pkg::ROWS_W-1:0];
                phbm_pkg::REG_ENERGY_FLOOR: energy_floor_reg <= pwdata[phbm_pkg::ENERGY_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            phbm_pkg::REG_ROW_COUNT:    prdata = phbm_pkg::CFG_DW'(row_count_reg);
            phbm_pkg::REG_ENERGY_FLOOR: prdata = phbm_pkg::CFG_DW'(energy_floor_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.row_count    = row_count_reg;
    assign cfg.energy_floor = energy_floor_reg;

endmodule

`default_nettype wire

FILE: hdl/phbm_state_ram.sv
`default_nettype none

module phbm_state_ram (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire phbm_pkg::ram_rd_t    rd,
    input  wire phbm_pkg::ram_wr_t    wr,
    output phbm_pkg::bar_state_t      rd_data
);

    phbm_pkg::bar_state_t         state_mem [phbm_pkg::MAX_BARS];
    logic [phbm_pkg::MAX_BARS-1:0] valid_reg;
    phbm_pkg::bar_state_t         rd_data_reg;
    logic                         rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            state_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= state_mem[rd.addr];
        end
    end

    // One valid bit per bar stands in for clearing the array after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: hdl/phbm_level_pipe.sv
`default_nettype none

module phbm_level_pipe (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire phbm_pkg::cfg_t        cfg,
    input  wire logic                  item_valid,
    input  wire phbm_pkg::item_t       item,
    output logic                       item_stall,
    output logic                       result_valid,
    output phbm_pkg::result_t          result,
    input  wire logic                  result_stall,
    output phbm_pkg::ram_rd_t          rd,
    input  wire phbm_pkg::bar_state_t  rd_data,
    output phbm_pkg::ram_wr_t          wr
);

    localparam int LW = phbm_pkg::LEVEL_W;
    localparam int FW = phbm_pkg::FALL_W;
    localparam int PW = phbm_pkg::PROD_W;
    localparam int GW = phbm_pkg::GAIN_W;

    function automatic logic [LW-1:0] snap_level(input logic [PW-1:0] p);
        logic [LW-1:0] y;
        y = p[PW-1:GW];
        return (y < phbm_pkg::SNAP_LIMIT) ? '0 : y;
    endfunction

    // ---------------- stage registers ----------------
    logic                          s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    phbm_pkg::item_t               s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    logic                          s1_range_reg, s2_range_reg, s3_range_reg, s4_range_reg;
    logic [phbm_pkg::ENERGY_W-1:0] s1_energy_reg;
    logic [LW-1:0]                 s2_target_reg;
    phbm_pkg::bar_state_t          s2_state_reg, s3_state_reg, s4_state_reg;
    logic [PW-1:0]                 s3_prod_reg;
    logic                          s3_up_reg;
    logic [FW-1:0]                 s3_fall_reg, s4_fall_reg;
    logic [LW-1:0]                 s4_bar_reg;
    logic [PW-1:0]                 s4_peak_prod_reg;
    logic                          result_valid_reg;
    phbm_pkg::result_t             result_reg;

    // ---------------- flow control ----------------
    logic out_free, s4_free, s3_free, s2_free, s1_free;
    logic s4_go, s3_go, s2_go, s1_go;
    logic hazard, accept;

    assign out_free = !result_valid_reg || !result_stall;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s4_go    = s4_valid_reg && out_free;
    assign s3_go    = s3_valid_reg && s4_free;
    assign s2_go    = s2_valid_reg && s3_free;
    assign s1_go    = s1_valid_reg && s2_free;

    // A bar still in flight has not been written back yet, so a second word
    // for the same bar waits until the first has left the last stage.
    assign hazard = (s1_valid_reg && s1_item_reg.bar_index == item.bar_index)
                 || (s2_valid_reg && s2_item_reg.bar_index == item.bar_index)
                 || (s3_valid_reg && s3_item_reg.bar_index == item.bar_index)
                 || (s4_valid_reg && s4_item_reg.bar_index == item.bar_index);

    assign item_stall = !s1_free || hazard;
    assign accept     = item_valid && !item_stall;

    assign rd.en   = accept;
    assign rd.addr = phbm_pkg::BAR_AW'(item.bar_index);

    // ---------------- input: clamp energy ----------------
    logic [phbm_pkg::ENERGY_W-1:0] e_floor, e_clamp;
    logic                          in_range;

    always_comb
    begin
        e_floor = (item.energy < cfg.energy_floor) ? cfg.energy_floor : item.energy;
        e_clamp = (e_floor > phbm_pkg::ONE_Q16) ? phbm_pkg::ONE_Q16 : e_floor;
    end

    assign in_range = (32'(item.bar_index) < 32'(phbm_pkg::MAX_BARS));

    // ---------------- stage 1: target ----------------
    logic [phbm_pkg::TPROD_W-1:0] target_prod;

    assign target_prod = phbm_pkg::TPROD_W'(s1_energy_reg)
                       * phbm_pkg::TPROD_W'(cfg.row_count);

    // ---------------- stage 2: gain multiply ----------------
    logic          s2_up;
    logic [LW-1:0] s2_diff, s2_mul_a;
    logic [GW-1:0] s2_mul_b;
    logic [PW-1:0] s2_prod;
    logic [FW:0]   s2_fall_sum;
    logic [FW-1:0] s2_fall;

    always_comb
    begin
        s2_up   = s2_target_reg > s2_state_reg.bar_level;
        s2_diff = s2_up ? (s2_target_reg - s2_state_reg.bar_level)
                        : (s2_state_reg.bar_level - s2_target_reg);
        if (s2_item_reg.active)
        begin
            s2_mul_a = s2_diff;
            s2_mul_b = s2_up ? s2_item_reg.attack_gain : s2_item_reg.decay_gain;
        end
        else
        begin
            s2_mul_a = s2_state_reg.bar_level;
            s2_mul_b = phbm_pkg::IDLE_GAIN;
        end
        s2_prod     = PW'(s2_mul_a) * PW'(s2_mul_b);
        s2_fall_sum = (FW+1)'(s2_state_reg.fall_speed) + (FW+1)'(s2_item_reg.fall_step);
        s2_fall     = s2_fall_sum[FW] ? phbm_pkg::FALL_MAX : s2_fall_sum[FW-1:0];
    end

    // ---------------- stage 3: new bar level, idle peak product ----------------
    logic [LW-1:0] s3_delta, s3_bar;
    logic [LW:0]   s3_sum;
    logic [PW-1:0] s3_peak_prod;

    always_comb
    begin
        s3_delta = s3_prod_reg[PW-1:GW];
        s3_sum   = (LW+1)'(s3_state_reg.bar_level) + (LW+1)'(s3_delta);
        if (!s3_item_reg.active)
        begin
            s3_bar = snap_level(s3_prod_reg);
        end
        else if (s3_up_reg)
        begin
            s3_bar = s3_sum[LW] ? phbm_pkg::LEVEL_MAX : s3_sum[LW-1:0];
        end
        else
        begin
            s3_bar = s3_state_reg.bar_level - s3_delta;
        end
        s3_peak_prod = PW'(s3_state_reg.peak_level) * PW'(phbm_pkg::IDLE_GAIN);
    end

    // ---------------- stage 4: peak hold and fall ----------------
    phbm_pkg::bar_state_t s4_new;
    logic [LW-1:0]        s4_peak_old, s4_peak_drop;
    phbm_pkg::result_t    s4_result;

    always_comb
    begin
        s4_peak_old  = s4_state_reg.peak_level;
        s4_peak_drop = s4_peak_old - s4_fall_reg[LW-1:0];
        s4_new       = s4_state_reg;
        s4_new.bar_level = s4_bar_reg;
        if (!s4_item_reg.active)
        begin
            s4_new.peak_level = snap_level(s4_peak_prod_reg);
        end
        else if (s4_bar_reg >= s4_peak_old)
        begin
            s4_new.peak_level = s4_bar_reg;
            s4_new.hold_count = s4_item_reg.hold_reload;
            s4_new.fall_speed = '0;
        end
        else if (s4_state_reg.hold_count != '0)
        begin
            s4_new.hold_count = s4_state_reg.hold_count - phbm_pkg::HOLD_W'(1);
        end
        else
        begin
            s4_new.fall_speed = s4_fall_reg;
            if (s4_fall_reg >= FW'(s4_peak_old) || s4_peak_drop < s4_bar_reg)
            begin
                s4_new.peak_level = s4_bar_reg;
            end
            else
            begin
                s4_new.peak_level = s4_peak_drop;
            end
        end

        s4_result.bar_out = s4_item_reg.bar_index;
        if (s4_range_reg)
        begin
            s4_result.bar_cells    = s4_new.bar_level[LW-1:LW-phbm_pkg::CELL_W];
            s4_result.eighths      = s4_new.bar_level[LW-phbm_pkg::CELL_W-1:LW-phbm_pkg::CELL_W-3];
            s4_result.peak_row     = s4_new.peak_level[LW-1:LW-phbm_pkg::CELL_W];
            s4_result.peak_visible = (s4_result.peak_row > s4_result.bar_cells)
                                  && (s4_result.peak_row < cfg.row_count);
        end
        else
        begin
            s4_result.bar_cells    = '0;
            s4_result.eighths      = '0;
            s4_result.peak_row     = '0;
            s4_result.peak_visible = 1'b0;
        end
    end

    assign wr.en   = s4_go && s4_range_reg;
    assign wr.addr = phbm_pkg::BAR_AW'(s4_item_reg.bar_index);
    assign wr.data = s4_new;

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free)
            begin
                result_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg   <= item;
            s1_range_reg  <= in_range;
            s1_energy_reg <= e_clamp;
        end
        if (s1_go)
        begin
            s2_item_reg   <= s1_item_reg;
            s2_range_reg  <= s1_range_reg;
            s2_state_reg  <= rd_data;
            s2_target_reg <= target_prod[phbm_pkg::TPROD_W-2:phbm_pkg::TPROD_W-2-LW+1];
        end
        if (s2_go)
        begin
            s3_item_reg  <= s2_item_reg;
            s3_range_reg <= s2_range_reg;
            s3_state_reg <= s2_state_reg;
            s3_prod_reg  <= s2_prod;
            s3_up_reg    <= s2_up;
            s3_fall_reg  <= s2_fall;
        end
        if (s3_go)
        begin
            s4_item_reg      <= s3_item_reg;
            s4_range_reg     <= s3_range_reg;
            s4_state_reg     <= s3_state_reg;
            s4_bar_reg       <= s3_bar;
            s4_peak_prod_reg <= s3_peak_prod;
            s4_fall_reg      <= s3_fall_reg;
        end
        if (s4_go)
        begin
            result_reg <= s4_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: hdl/peak_hold_bar_meter_top.sv
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    phbm_pkg::item_t, one bar update
// result    out        result_valid / result_stall phbm_pkg::result_t, one per item
// config    in         APB psel/penable/pwrite     row_count at 0x0, energy_floor at 0x4
//
// One word is taken per cycle while its bar is not in a stage and the output is free.
// An accepted word passes through four arithmetic stages and leaves through the output
// register, the read of the per-bar store overlapping the first stage.
// A word whose bar is still in one of the four stages is held off until that bar's
// state is written back, so in a run on one bar each word waits for the one before.
// Reset clears the per-bar valid bits at once, so there is no clearing pass.
// A stalled output keeps its word; the stages behind it close up their bubbles first.
`default_nettype none

module peak_hold_bar_meter_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire phbm_pkg::item_t              item,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output phbm_pkg::result_t                 result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [phbm_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [phbm_pkg::CFG_DW-1:0]  pwdata,
    output logic      [phbm_pkg::CFG_DW-1:0]  prdata,
    output logic                              pready
);

    // Configuration values shared with the pipeline.  The user is to change them only while
    // the meter is idle; the block does not enforce this, and the stages read them directly.
    phbm_pkg::cfg_t       cfg;

    // Read and write ports of the per-bar state store.  The read is issued
    // when a word is accepted and its data lines up with the first stage; the
    // write-back happens as the word leaves the last stage.
    phbm_pkg::ram_rd_t    ram_rd;
    phbm_pkg::ram_wr_t    ram_wr;
    phbm_pkg::bar_state_t ram_rd_data;

    phbm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Bar level, peak level, hold count and fall speed for every bar.  An
    // entry not yet written reads back as zero, which is the reset state.
    phbm_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (ram_rd),
        .wr      (ram_wr),
        .rd_data (ram_rd_data)
    );

    // Stage 1 forms the target level from the clamped energy, stage 2 applies
    // the attack, decay or idle gain, stage 3 settles the bar level and the
    // idle peak product, and stage 4 runs the peak hold and fall before the
    // result is registered.
    phbm_level_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item         (item),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall),
        .rd           (ram_rd),
        .rd_data      (ram_rd_data),
        .wr           (ram_wr)
    );

endmodule

`default_nettype wire

FILE: hdl/phbm_port_checker.sv
`default_nettype none

`include "peak_hold_bar_meter_top_defines.svh"

module phbm_port_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         item_valid,
    input wire logic                         item_stall,
    input wire phbm_pkg::item_t              item,
    input wire logic                         result_valid,
    input wire logic                         result_stall,
    input wire phbm_pkg::result_t            result,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [phbm_pkg::CFG_AW-1:0]  paddr,
    input wire logic [phbm_pkg::CFG_DW-1:0]  pwdata,
    input wire logic [phbm_pkg::CFG_DW-1:0]  prdata,
    input wire logic                         pready
);

    // A held result keeps its word.
`PHBM_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
    result_valid && $stable(result), "stalled result changed")

    // A visible peak must sit above the bar top.
`PHBM_ASSERT_NOW(a_peak_above, result_valid && result.peak_visible,
    result.peak_row > result.bar_cells, "peak shown at or below bar")

    // A bar just taken in may not be taken again in the next cycle.
`PHBM_ASSERT_NEXT(a_bar_interlock, item_valid && !item_stall,
    !(item_valid && item.bar_index == $past(item.bar_index)) || item_stall,
    "same bar accepted twice in a row")

    // The row count reads back what was written.
`PHBM_ASSERT_NEXT(a_rows_readback, psel && penable && pwrite && pready && paddr[2] == 1'b0,
    !(psel && !pwrite && paddr[2] == 1'b0) || prdata[7:0] == $past(pwdata[7:0]),
    "row count readback mismatch")

endmodule

bind peak_hold_bar_meter_top phbm_port_checker u_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
);

`default_nettype wire
